@@ rtl/tcpq_pkg.sv @@
// shared types and constants for the two-class priority byte queue
// no dependencies
package tcpq_pkg;
  localparam int unsigned RingDepthDefault = 64;
  localparam logic [23:0] MaxBytesReset = 24'd6553500;
  localparam logic [23:0] MarkThReset = 24'd5;
  localparam int unsigned EntryWidth = 40;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_DEQUEUED = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef enum logic {
    REG_MAX_BYTES = 1'b0,
    REG_MARK_TH   = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic        kind;
    logic        high_class;
    logic [15:0] packet_id;
    logic [15:0] packet_bytes;
    logic [7:0]  tos_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        was_marked;
    logic [15:0] out_id;
    logic [15:0] out_bytes;
    logic [7:0]  tos_out;
    logic [6:0]  evicted_count;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [23:0] data;
  } cfg_item_t;

  function automatic logic [8:0] mark_tos(input logic [7:0] tos);
    logic [7:0] cnt;
    if (tos[1:0] == 2'b00) begin
      return {1'b0, tos};
    end
    cnt = {3'b000, tos[4:2] + 3'd1, 2'b00};
    if (tos[4:2] == 3'd7) cnt = 8'h20;
    return {1'b1, ((tos | 8'h0F) & cnt) | 8'h03};
  endfunction
endpackage

@@ rtl/tcpq_if.sv @@
// valid/ready stream interfaces for items and configuration writes
// depends on tcpq_pkg
interface tcpq_in_if;
  logic valid;
  logic ready;
  tcpq_pkg::in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface tcpq_out_if;
  logic valid;
  logic ready;
  tcpq_pkg::out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface tcpq_cfg_if;
  logic valid;
  logic ready;
  tcpq_pkg::cfg_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ rtl/two_class_priority_byte_queue.sv @@
// Two-class strict-priority byte queue with push-out and ECN marking.
// Channels: in_if (enqueue descriptor or dequeue request), out_if (one result
// beat per input beat), cfg_if (register 0 max_bytes, 1 mark_threshold).
// Each item runs through a small sequencer around one shared 25-bit
// add/compare unit and two single-port descriptor rams.
// An enqueue or an empty dequeue goes from S_EXEC to S_OUT; a dequeue of a
// stored entry passes through S_DQRD to take the ram's registered read data.
// A high enqueue that pushes out low entries returns through S_EVRD to S_EXEC
// once per evicted entry, as the low ram's read port is registered.
// in_if.ready is high only in idle; the next item is taken the cycle after
// its result beat is taken. While the receiver stalls, the result holds in
// the output register and no new item is taken.
// Reset empties both queues, clears the byte count and loads max_bytes with
// 6553500 and mark_threshold with 5; ram contents are left as they are.
// cfg_if is always ready; writes take effect at once and are meant for idle.
module two_class_priority_byte_queue
  import tcpq_pkg::*;
#(
  parameter int unsigned RingDepth = RingDepthDefault
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  tcpq_in_if.sink    in_if,
  tcpq_out_if.source out_if,
  tcpq_cfg_if.sink   cfg_if
);
  localparam int unsigned Aw = $clog2(RingDepth);
  localparam int unsigned Cw = $clog2(RingDepth + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_EVRD  = 6'b000100,
    S_EVSUB = 6'b001000,
    S_DQRD  = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  in_item_t item_q, item_d;
  out_item_t res_q, res_d;
  logic [23:0] max_q, th_q, bytes_q, bytes_d;
  logic [Aw-1:0] hh_q, hh_d, lh_q, lh_d;
  logic [Cw-1:0] hc_q, hc_d, lc_q, lc_d;
  logic deq_hi_q, deq_hi_d;

  // ram ports
  logic h_we, l_we;
  logic [Aw-1:0] h_addr, l_addr;
  logic [EntryWidth-1:0] h_wdata, l_wdata, h_rdata, l_rdata;

  tcpq_ram #(.Width(EntryWidth), .Depth(RingDepth)) u_high (
    .clk_i, .we_i(h_we), .addr_i(h_addr), .wdata_i(h_wdata), .rdata_o(h_rdata));
  tcpq_ram #(.Width(EntryWidth), .Depth(RingDepth)) u_low (
    .clk_i, .we_i(l_we), .addr_i(l_addr), .wdata_i(l_wdata), .rdata_o(l_rdata));

  // shared add/compare unit
  logic [23:0] alu_a, alu_b;
  logic alu_sub;
  logic [24:0] alu_r;
  always_comb begin
    if (alu_sub) alu_r = {1'b0, alu_a} - {1'b0, alu_b};
    else alu_r = {1'b0, alu_a} + {1'b0, alu_b};
  end

  function automatic logic [Aw-1:0] wrap_add(logic [Aw-1:0] h, logic [Cw-1:0] c);
    logic [Cw:0] s;
    s = {{(Cw+1-Aw){1'b0}}, h} + {1'b0, c};
    if (s >= (Cw+1)'(RingDepth)) s = s - (Cw+1)'(RingDepth);
    return s[Aw-1:0];
  endfunction

  logic [23:0] ev_bytes, deq_bytes;
  logic [8:0] mk;

  always_comb begin
    state_d = state_q; item_d = item_q; res_d = res_q; bytes_d = bytes_q;
    hh_d = hh_q; hc_d = hc_q; lh_d = lh_q; lc_d = lc_q; deq_hi_d = deq_hi_q;
    h_we = 1'b0; l_we = 1'b0;
    h_addr = hh_q; l_addr = lh_q;
    h_wdata = {item_q.tos_in, item_q.packet_bytes, item_q.packet_id};
    l_wdata = h_wdata;
    alu_a = bytes_q; alu_b = {8'd0, item_q.packet_bytes}; alu_sub = 1'b0;
    ev_bytes = {8'd0, l_rdata[31:16]};
    deq_bytes = deq_hi_q ? {8'd0, h_rdata[31:16]} : {8'd0, l_rdata[31:16]};
    mk = mark_tos(item_q.tos_in);
    unique case (state_q)
      S_IDLE: begin
        if (in_if.valid) begin
          item_d = in_if.data;
          state_d = S_EXEC;
          res_d = '0;
          res_d.out_id = in_if.data.packet_id;
          res_d.out_bytes = in_if.data.packet_bytes;
          res_d.tos_out = in_if.data.tos_in;
        end
      end
      S_EXEC: begin
        if (item_q.kind) begin
          if (hc_q != '0) begin
            deq_hi_d = 1'b1; h_addr = hh_q; state_d = S_DQRD;
          end else if (lc_q != '0) begin
            deq_hi_d = 1'b0; l_addr = lh_q; state_d = S_DQRD;
          end else begin
            res_d = '0; res_d.status = ST_EMPTY; state_d = S_OUT;
          end
        end else if (item_q.high_class) begin
          if (hc_q == Cw'(RingDepth)) begin
            res_d.status = ST_DROPPED; state_d = S_OUT;
          end else if (alu_r > {1'b0, max_q} && lc_q != '0) begin
            l_addr = wrap_add(lh_q, lc_q - Cw'(1));
            lc_d = lc_q - Cw'(1);
            state_d = S_EVRD;
          end else begin
            if (alu_r < {1'b0, max_q}) begin
              bytes_d = alu_r[23:0];
              h_we = 1'b1; h_addr = wrap_add(hh_q, hc_q);
              hc_d = hc_q + Cw'(1);
              res_d.status = ST_ACCEPTED;
            end else begin
              res_d.status = ST_DROPPED;
            end
            state_d = S_OUT;
          end
        end else begin
          if (alu_r >= {1'b0, th_q}) begin
            res_d.was_marked = mk[8]; res_d.tos_out = mk[7:0];
          end
          if (alu_r >= {1'b0, max_q} || lc_q == Cw'(RingDepth)) begin
            res_d.status = ST_DROPPED;
          end else begin
            bytes_d = alu_r[23:0];
            l_we = 1'b1; l_addr = wrap_add(lh_q, lc_q);
            l_wdata = {(alu_r >= {1'b0, th_q}) ? mk[7:0] : item_q.tos_in,
                       item_q.packet_bytes, item_q.packet_id};
            lc_d = lc_q + Cw'(1);
            res_d.status = ST_ACCEPTED;
          end
          state_d = S_OUT;
        end
      end
      S_EVRD: begin
        // tail entry is on the read port; release its bytes
        alu_a = bytes_q; alu_b = ev_bytes; alu_sub = 1'b1;
        bytes_d = alu_r[24] ? 24'd0 : alu_r[23:0];
        if (res_q.evicted_count != 7'd127)
          res_d.evicted_count = res_q.evicted_count + 7'd1;
        state_d = S_EXEC;
      end
      S_DQRD: begin
        alu_a = bytes_q; alu_b = deq_bytes; alu_sub = 1'b1;
        bytes_d = alu_r[24] ? 24'd0 : alu_r[23:0];
        res_d.status = ST_DEQUEUED;
        res_d.was_marked = 1'b0;
        if (deq_hi_q) begin
          res_d.out_id = h_rdata[15:0]; res_d.out_bytes = h_rdata[31:16];
          res_d.tos_out = h_rdata[39:32];
          hh_d = wrap_add(hh_q, Cw'(1)); hc_d = hc_q - Cw'(1);
        end else begin
          res_d.out_id = l_rdata[15:0]; res_d.out_bytes = l_rdata[31:16];
          res_d.tos_out = l_rdata[39:32];
          lh_d = wrap_add(lh_q, Cw'(1)); lc_d = lc_q - Cw'(1);
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_if.ready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_if.ready  = (state_q == S_IDLE);
  assign out_if.valid = (state_q == S_OUT);
  assign out_if.data  = res_q;
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      bytes_q <= '0;
      hh_q <= '0; hc_q <= '0; lh_q <= '0; lc_q <= '0;
      max_q <= MaxBytesReset;
      th_q <= MarkThReset;
      deq_hi_q <= 1'b0;
    end else begin
      state_q <= state_d;
      bytes_q <= bytes_d;
      hh_q <= hh_d; hc_q <= hc_d; lh_q <= lh_d; lc_q <= lc_d;
      deq_hi_q <= deq_hi_d;
      if (cfg_if.valid && cfg_if.data.index[1] == 1'b0) begin
        unique case (reg_idx_e'(cfg_if.data.index[0]))
          REG_MAX_BYTES: max_q <= cfg_if.data.data;
          REG_MARK_TH:   th_q <= cfg_if.data.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q <= res_d;
  end
endmodule

@@ rtl/tcpq_ram.sv @@
// generic single-port ram with registered read
// no dependencies
module tcpq_ram #(
  parameter int unsigned Width = 40,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

@@ rtl/tcpq_checker.sv @@
// port-level checks for the two-class priority byte queue
// depends on tcpq_pkg and the top level, attached by bind
module tcpq_checker
  import tcpq_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_item_t out_data
);
  // one item in flight: no input beat while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("input taken with result pending");
  // no second input beat right after an accepted one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) |=> !in_ready) else $error("ready after accept");
  // empty and dequeued results carry no marking or eviction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && (out_data.status == ST_EMPTY || out_data.status == ST_DEQUEUED))
      |-> (!out_data.was_marked && out_data.evicted_count == 7'd0))
    else $error("bad dequeue result");
  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result dropped");
endmodule

bind two_class_priority_byte_queue tcpq_checker u_tcpq_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .out_data(out_if.data));

@@ sim/tb_two_class_priority_byte_queue.sv @@
`timescale 1ns / 1ps
// self-checking testbench for two_class_priority_byte_queue
// keeps its own copy of both descriptor fifos and the byte count in a scoreboard
// depends on tcpq_pkg, tcpq_if and the queue rtl
module tb_two_class_priority_byte_queue;
  import tcpq_pkg::*;

  localparam int unsigned WatchLimit = 6000;

  class byte_queue_scoreboard;
    typedef struct packed {
      logic [15:0] id;
      logic [15:0] nbytes;
      logic [7:0]  tos;
    } desc_t;

    desc_t       hi_fifo[$];
    desc_t       lo_fifo[$];
    int unsigned held;
    logic [23:0] limit_bytes;
    logic [23:0] mark_level;
    out_item_t   expected_q[$];
    int          errors;

    function new();
      held = 0;
      limit_bytes = MaxBytesReset;
      mark_level = MarkThReset;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [23:0] v);
      if (idx == REG_MAX_BYTES) limit_bytes = v;
      else if (idx == REG_MARK_TH) mark_level = v;
    endfunction

    function void release_bytes(logic [15:0] n);
      held = (held >= n) ? held - n : 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_input(in_item_t it);
      out_item_t   r;
      desc_t       d;
      int unsigned sum;
      logic [7:0]  cnt;
      r = '0;
      r.status = ST_ACCEPTED;
      r.out_id = it.packet_id;
      r.out_bytes = it.packet_bytes;
      r.tos_out = it.tos_in;
      if (it.kind) begin
        if (hi_fifo.size() + lo_fifo.size() == 0) begin
          r.status = ST_EMPTY;
          r.out_id = '0;
          r.out_bytes = '0;
          r.tos_out = '0;
        end else begin
          if (hi_fifo.size() != 0) begin
            d = hi_fifo[0];
            hi_fifo.delete(0);
          end else begin
            d = lo_fifo[0];
            lo_fifo.delete(0);
          end
          r.status = ST_DEQUEUED;
          r.out_id = d.id;
          r.out_bytes = d.nbytes;
          r.tos_out = d.tos;
          release_bytes(d.nbytes);
        end
      end else if (it.high_class) begin
        if (hi_fifo.size() >= RingDepthDefault) begin
          r.status = ST_DROPPED;
        end else begin
          // push out low tail entries while the total would exceed the limit and low entries remain
          if (held + it.packet_bytes >= limit_bytes) begin
            while (held + it.packet_bytes > limit_bytes && lo_fifo.size() != 0) begin
              d = lo_fifo[lo_fifo.size() - 1];
              lo_fifo.delete(lo_fifo.size() - 1);
              release_bytes(d.nbytes);
              if (r.evicted_count < 7'd127) r.evicted_count++;
            end
          end
          if (held + it.packet_bytes < limit_bytes) begin
            held += it.packet_bytes;
            d.id = it.packet_id;
            d.nbytes = it.packet_bytes;
            d.tos = it.tos_in;
            hi_fifo.insert(hi_fifo.size(), d);
          end else begin
            r.status = ST_DROPPED;
          end
        end
      end else begin
        sum = held + it.packet_bytes;
        if (sum >= mark_level && it.tos_in[1:0] != 2'b00) begin
          cnt = {3'b000, it.tos_in[4:2], 2'b00} + 8'd4;
          r.tos_out = ((it.tos_in | 8'h0F) & cnt) | 8'h03;
          r.was_marked = 1'b1;
        end
        if (sum >= limit_bytes || lo_fifo.size() >= RingDepthDefault) begin
          r.status = ST_DROPPED;
        end else begin
          held = sum;
          d.id = it.packet_id;
          d.nbytes = it.packet_bytes;
          d.tos = r.tos_out;
          lo_fifo.insert(lo_fifo.size(), d);
        end
      end
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void check(out_item_t got);
      out_item_t e;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        errors++;
        return;
      end
      e = expected_q[0];
      expected_q.delete(0);
      if (got.status !== e.status) begin
        $error("status expected %0d got %0d", e.status, got.status);
        errors++;
      end
      if (got.was_marked !== e.was_marked) begin
        $error("was_marked expected %0d got %0d", e.was_marked, got.was_marked);
        errors++;
      end
      if (got.out_id !== e.out_id) begin
        $error("out_id expected %0h got %0h", e.out_id, got.out_id);
        errors++;
      end
      if (got.out_bytes !== e.out_bytes) begin
        $error("out_bytes expected %0d got %0d", e.out_bytes, got.out_bytes);
        errors++;
      end
      if (got.tos_out !== e.tos_out) begin
        $error("tos_out expected %0h got %0h", e.tos_out, got.tos_out);
        errors++;
      end
      if (got.evicted_count !== e.evicted_count) begin
        $error("evicted_count expected %0d got %0d", e.evicted_count, got.evicted_count);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  tcpq_in_if  in_if();
  tcpq_out_if out_if();
  tcpq_cfg_if cfg_if();

  two_class_priority_byte_queue uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if),
    .out_if(out_if),
    .cfg_if(cfg_if)
  );

  byte_queue_scoreboard sb = new();
  int unsigned idle_cycles = 0;
  bit long_hold = 0;
  bit no_gaps = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    in_if.valid <= 1'b0;
    in_if.data <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= '0;
    out_if.ready <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // beat monitors feed the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) sb.note_input(in_if.data);
      if (out_if.valid && out_if.ready) sb.check(out_if.data);
      if (cfg_if.valid && cfg_if.ready) sb.write_reg(cfg_if.data.index, cfg_if.data.data);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == WatchLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        out_if.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        long_hold = 0;
      end else if (no_gaps || $urandom_range(0, 3) != 0) begin
        out_if.ready <= 1'b1;
        n = $urandom_range(1, 20);
        repeat (n) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b0;
        n = pick_gap() + 1;
        repeat (n) @(posedge clk_i);
      end
    end
  end

  task automatic send_item(in_item_t it);
    int gap;
    in_if.valid <= 1'b1;
    in_if.data <= it;
    do @(posedge clk_i); while (!in_if.ready);
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [23:0] v);
    wait_drained();
    repeat (8) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= '{index: {1'b0, idx}, data: v};
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic in_item_t mk(bit kind, bit hi, logic [15:0] id, logic [15:0] nb,
                                  logic [7:0] tos);
    in_item_t it;
    it.kind = kind;
    it.high_class = hi;
    it.packet_id = id;
    it.packet_bytes = nb;
    it.tos_in = tos;
    return it;
  endfunction

  function automatic logic [15:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 16'($urandom_range(1, 400));
    if (r < 85) return 16'($urandom_range(1, 65535));
    if (r < 95) return 16'hFFFF;
    return 16'd1;
  endfunction

  // segments of enqueue-heavy, dequeue-heavy or mixed traffic, sometimes one class
  task automatic random_items(int n);
    int left;
    int seg;
    int deq_pct;
    int cls;
    bit hi;
    in_item_t it;
    left = n;
    while (left > 0) begin
      seg = $urandom_range(10, 90);
      case ($urandom_range(0, 2))
        0: deq_pct = 45;
        1: deq_pct = 6;
        default: deq_pct = 85;
      endcase
      cls = $urandom_range(0, 2);
      no_gaps = ($urandom_range(0, 3) == 0);
      while (seg > 0 && left > 0) begin
        hi = (cls == 0) ? 1'($urandom_range(0, 1)) : (cls == 1);
        it = mk($urandom_range(0, 99) < deq_pct, hi, 16'($urandom_range(0, 65535)),
                pick_size(), 8'($urandom_range(0, 255)));
        send_item(it);
        seg--;
        left--;
      end
    end
    no_gaps = 0;
  endtask

  initial begin
    @(posedge rst_ni);
    @(posedge clk_i);
    // directed: empty dequeue, marking edges, extremes of the fields
    send_item(mk(1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 8'hFF));
    send_item(mk(1'b0, 1'b0, 16'h0000, 16'd1, 8'h00));
    send_item(mk(1'b0, 1'b0, 16'h0001, 16'd4, 8'h03));
    send_item(mk(1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 8'h1F));
    send_item(mk(1'b0, 1'b0, 16'h1234, 16'd7, 8'hFF));
    send_item(mk(1'b0, 1'b0, 16'h5678, 16'd9, 8'hE1));
    send_item(mk(1'b0, 1'b0, 16'h00AA, 16'd0, 8'h1C));
    send_item(mk(1'b0, 1'b1, 16'h0000, 16'hFFFF, 8'hFF));
    send_item(mk(1'b0, 1'b1, 16'hFFFF, 16'd0, 8'h00));
    repeat (8) send_item(mk(1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 8'hFF));
    random_items(140);

    write_reg(REG_MAX_BYTES, 24'd2000);
    write_reg(REG_MARK_TH, 24'd800);
    // push-out of two low entries by one high arrival, then an exact-limit drop
    send_item(mk(1'b0, 1'b0, 16'h0101, 16'd900, 8'h02));
    send_item(mk(1'b0, 1'b0, 16'h0102, 16'd900, 8'h01));
    send_item(mk(1'b0, 1'b1, 16'h0201, 16'd1500, 8'h00));
    send_item(mk(1'b0, 1'b1, 16'h0202, 16'd500, 8'h00));
    random_items(80);
    // sender waits for every result before going on
    wait_drained();
    repeat (20) @(posedge clk_i);
    random_items(80);

    write_reg(REG_MAX_BYTES, 24'hFFFFFF);
    write_reg(REG_MARK_TH, 24'd0);
    long_hold = 1;
    random_items(130);

    write_reg(REG_MAX_BYTES, 24'd0);
    write_reg(REG_MARK_TH, 24'hFFFFFF);
    random_items(30);

    write_reg(REG_MAX_BYTES, 24'd5000);
    write_reg(REG_MARK_TH, 24'd2500);
    random_items(150);

    wait_drained();
    repeat (30) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

@@ two_class_priority_byte_queue.f @@
rtl/tcpq_pkg.sv
rtl/tcpq_if.sv
rtl/tcpq_ram.sv
rtl/two_class_priority_byte_queue.sv
rtl/tcpq_checker.sv
sim/tb_two_class_priority_byte_queue.sv
